// ----- src/icaf_pkg.sv -----
// ---------------------------------------------------------------------------
// icaf_pkg: shared types and constants of the attitude filter
// Number formats, datapath operation codes, controller/datapath buses.
// ---------------------------------------------------------------------------
package icaf_pkg;

    // field widths
    localparam int SAMP_W      = 16;
    localparam int ANGLE_W     = 17;
    localparam int GAIN_W      = 16;
    localparam int PER_W       = 16;
    localparam int LSB_W       = 11;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;

    // fixed-point settings
    localparam int ANGLE_FRAC_BITS  = 8;
    localparam int INIT_SAMPLES_MAX = 5;
    localparam int CNT_W            = 4;
    localparam int SUM_W            = 20;
    localparam int EXT_W            = 24;   // unwrapped angle width
    localparam int HALF_TURN        = 180 * (2 ** ANGLE_FRAC_BITS);
    localparam int FULL_TURN        = 360 * (2 ** ANGLE_FRAC_BITS);
    localparam int WRAP_STEPS       = 6;    // greedy 360 removal, 2^5 .. 2^0

    // CORDIC
    localparam int CORDIC_STEPS    = 16;
    localparam int CORDIC_W        = 33;
    localparam int CORDIC_PRESHIFT = 14;
    localparam int Z_W             = 26;
    localparam int DEG180_Q16      = 11796480;
    localparam logic [Z_W-1:0] ATAN_TAB [CORDIC_STEPS] = '{
        26'd2949120, 26'd1740967, 26'd919879, 26'd466945,
        26'd234379,  26'd117304,  26'd58666,  26'd29335,
        26'd14668,   26'd7334,    26'd3667,   26'd1833,
        26'd917,     26'd458,     26'd229,    26'd115
    };

    // divider
    localparam int DIV_W     = 40;
    localparam int DVS_W     = 28;
    localparam int LSB_SCALE = 100000;

    // blend
    localparam int WGT_W     = 18;
    localparam int PROD_W    = WGT_W + EXT_W;
    localparam int BSUM_W    = PROD_W + 1;
    localparam int GAIN_ONE  = 65536;
    localparam int GAIN_HALF = 32768;

    // datapath phase counter
    localparam int PH_W          = 6;
    localparam int PH_ATAN_LAST  = CORDIC_STEPS + 1;
    localparam int PH_DIV_LAST   = DIV_W + 2;
    localparam int PH_WRAP_FIRST = 3;
    localparam int PH_WRAP_LAST  = PH_WRAP_FIRST + WRAP_STEPS;

    // register reset values
    localparam logic [GAIN_W-1:0] GAIN_RST   = 16'd52429;
    localparam logic [PER_W-1:0]  PERIOD_RST = 16'd5000;
    localparam logic [LSB_W-1:0]  LSB_RST    = 11'd164;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BLEND_GAIN = 2'd0,
        CFG_PERIOD     = 2'd1,
        CFG_GYRO_LSB   = 2'd2
    } t_cfg_idx;

    typedef enum logic [3:0] {
        OP_ATAN_R,
        OP_ATAN_P,
        OP_ACCUM,
        OP_INIT_R,
        OP_INIT_P,
        OP_INIT_FIN,
        OP_GYRO_X,
        OP_GYRO_Y,
        OP_GYRO_Z,
        OP_BLEND_R,
        OP_BLEND_P,
        OP_WRAP_Y
    } t_dp_op;

    typedef struct packed {
        logic   load;
        logic   start;
        t_dp_op op;
        logic   capture;
    } t_dp_cmd;

    typedef struct packed {
        logic busy;
        logic done;
        logic operation;
        logic sample_ok;
        logic init_pending;
        logic count_zero;
        logic count_room;
    } t_dp_sts;

endpackage

// ----- src/icaf_if.sv -----
// ---------------------------------------------------------------------------
// icaf interfaces: sample, result and configuration channels
// Valid/ready channels; an item moves when both are high at a clock edge.
// ---------------------------------------------------------------------------
interface icaf_sample_if import icaf_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic                     operation;
    logic                     sample_ok;
    logic signed [SAMP_W-1:0] accel_x;
    logic signed [SAMP_W-1:0] accel_y;
    logic signed [SAMP_W-1:0] accel_z;
    logic signed [SAMP_W-1:0] gyro_x;
    logic signed [SAMP_W-1:0] gyro_y;
    logic signed [SAMP_W-1:0] gyro_z;

    modport source (output valid, operation, sample_ok, accel_x, accel_y, accel_z,
                    gyro_x, gyro_y, gyro_z, input ready);
    modport sink   (input valid, operation, sample_ok, accel_x, accel_y, accel_z,
                    gyro_x, gyro_y, gyro_z, output ready);
endinterface

interface icaf_result_if import icaf_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [ANGLE_W-1:0] roll_angle;
    logic signed [ANGLE_W-1:0] pitch_angle;
    logic signed [ANGLE_W-1:0] yaw_angle;

    modport source (output valid, roll_angle, pitch_angle, yaw_angle, input ready);
    modport sink   (input valid, roll_angle, pitch_angle, yaw_angle, output ready);
endinterface

interface icaf_cfg_if import icaf_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- src/imu_complementary_attitude_filter.sv -----
// ---------------------------------------------------------------------------
// imu_complementary_attitude_filter: roll/pitch/yaw complementary filter
//
//   channel   dir  handshake      payload
//   i_sample  in   valid/ready    operation, sample_ok, accel_x/y/z, gyro_x/y/z
//   o_result  out  valid/ready    roll_angle, pitch_angle, yaw_angle
//   i_cfg     in   valid/ready    index, data (ready always high)
//
// One item at a time. A good init sample runs two CORDIC passes, and a good
// update runs the divider (40 restoring steps) once per gyro axis; the first
// update adds two more divider runs and a finish. Synchronous active-low
// reset; no clearing pass. The result waits in an output register, and the
// next item is taken while it waits.
// ---------------------------------------------------------------------------
module imu_complementary_attitude_filter import icaf_pkg::*; (
    input  logic           i_clk,
    input  logic           i_rst_n,
    icaf_sample_if.sink    i_sample,
    icaf_result_if.source  o_result,
    icaf_cfg_if.sink       i_cfg
);

    t_dp_cmd cmd;
    t_dp_sts sts;
    logic    in_ready;
    logic    out_valid;

    assign i_cfg.ready    = 1'b1;
    assign i_sample.ready = in_ready;
    assign o_result.valid = out_valid;

    icaf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_sample.valid),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .i_out_ready (o_result.ready),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    icaf_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_operation (i_sample.operation),
        .i_sample_ok (i_sample.sample_ok),
        .i_accel_x   (i_sample.accel_x),
        .i_accel_y   (i_sample.accel_y),
        .i_accel_z   (i_sample.accel_z),
        .i_gyro_x    (i_sample.gyro_x),
        .i_gyro_y    (i_sample.gyro_y),
        .i_gyro_z    (i_sample.gyro_z),
        .i_cfg_we    (i_cfg.valid),
        .i_cfg_idx   (i_cfg.index),
        .i_cfg_data  (i_cfg.data),
        .o_roll      (o_result.roll_angle),
        .o_pitch     (o_result.pitch_angle),
        .o_yaw       (o_result.yaw_angle)
    );

`ifndef SYNTH
    // only one item in flight
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_sample.valid && i_sample.ready) |=> !i_sample.ready)
        else $error("sample taken while an item is in flight");

    // controller never starts an operation over a running one
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.start |-> !sts.busy)
        else $error("datapath operation started while busy");

    // delivered yaw stays within the wrapped band
    a_yaw_band: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid |-> ($signed(o_result.yaw_angle) <= HALF_TURN) &&
                           ($signed(o_result.yaw_angle) >= -HALF_TURN))
        else $error("yaw outside plus or minus 180 degrees");
`endif

endmodule

// ----- src/icaf_dp.sv -----
// ---------------------------------------------------------------------------
// icaf_dp: attitude filter datapath
// Config registers, sample latch, filter state, iterative CORDIC, restoring
// divider, blend multiplier and angle wrap, run one operation at a time.
// ---------------------------------------------------------------------------
module icaf_dp import icaf_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_dp_cmd                   i_cmd,
    output t_dp_sts                   o_sts,
    input  logic                      i_operation,
    input  logic                      i_sample_ok,
    input  logic signed [SAMP_W-1:0]  i_accel_x,
    input  logic signed [SAMP_W-1:0]  i_accel_y,
    input  logic signed [SAMP_W-1:0]  i_accel_z,
    input  logic signed [SAMP_W-1:0]  i_gyro_x,
    input  logic signed [SAMP_W-1:0]  i_gyro_y,
    input  logic signed [SAMP_W-1:0]  i_gyro_z,
    input  logic                      i_cfg_we,
    input  logic [CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]     i_cfg_data,
    output logic signed [ANGLE_W-1:0] o_roll,
    output logic signed [ANGLE_W-1:0] o_pitch,
    output logic signed [ANGLE_W-1:0] o_yaw
);

    // config registers
    logic [GAIN_W-1:0] r_gain;
    logic [PER_W-1:0]  r_period;
    logic [LSB_W-1:0]  r_lsb;

    // latched sample
    logic                     r_op, r_ok;
    logic signed [SAMP_W-1:0] r_ax, r_ay, r_az, r_gx, r_gy, r_gz;

    // filter state
    logic signed [ANGLE_W-1:0] r_roll, r_pitch, r_yaw;
    logic signed [SUM_W-1:0]   r_sum_r, r_sum_p;
    logic [CNT_W-1:0]          r_count;
    logic                      r_pending;

    // sequencing
    logic            r_busy;
    t_dp_op          r_cur;
    logic [PH_W-1:0] r_cnt;
    logic [PH_W-1:0] ph_last;
    logic            done;

    // CORDIC
    logic signed [CORDIC_W-1:0] r_cx, r_cy;
    logic signed [Z_W-1:0]      r_cz;
    logic                       r_zero;
    logic signed [ANGLE_W-1:0]  r_ar, r_ap;

    // divider
    logic [DIV_W-1:0] r_mag, r_quo;
    logic [DVS_W-1:0] r_dv, r_rem;
    logic             r_neg;

    // gyro-advanced angles and blend
    logic signed [EXT_W-1:0]  r_rg, r_pg, r_yg;
    logic signed [PROD_W-1:0] r_m1, r_m2;
    logic signed [EXT_W-1:0]  r_wv;

    logic signed [ANGLE_W-1:0] r_out_roll, r_out_pitch, r_out_yaw;

    // combinational helpers
    logic signed [SAMP_W:0]     y_src, x_src;
    logic signed [CORDIC_W-1:0] x_init, y_init, xs, ys;
    logic [3:0]                 c_idx;
    logic signed [Z_W-1:0]      z_rnd;
    logic signed [ANGLE_W:0]    z_w, z_fix;
    logic signed [SAMP_W-1:0]   g_sel;
    logic [SAMP_W-1:0]          g_mag;
    logic [LSB_W-1:0]           lsb_eff;
    logic [DVS_W-1:0]           d_gyro;
    logic [PER_W+SAMP_W-1:0]    g_prod;
    logic signed [SUM_W-1:0]    sum_sel;
    logic [SUM_W-1:0]           sum_mag;
    logic [DVS_W:0]             trial;
    logic                       ge;
    logic [EXT_W-1:0]           q_lo;
    logic signed [EXT_W-1:0]    q_sgn;
    logic signed [ANGLE_W-1:0]  est_sel;
    logic signed [EXT_W-1:0]    gyro_ang, acc_ang;
    logic signed [WGT_W-1:0]    w_gyro, w_acc;
    logic signed [BSUM_W-1:0]   bsum;
    logic [2:0]                 w_k;
    logic signed [EXT_W:0]      wv_e, w_step, t_dn, t_up, w_fin;
    logic                       is_gyro;

    // phase count of the running operation
    always_comb begin
        unique case (r_cur)
            OP_ATAN_R, OP_ATAN_P:                            ph_last = PH_W'(PH_ATAN_LAST);
            OP_INIT_R, OP_INIT_P,
            OP_GYRO_X, OP_GYRO_Y, OP_GYRO_Z:                 ph_last = PH_W'(PH_DIV_LAST);
            OP_BLEND_R, OP_BLEND_P, OP_WRAP_Y:               ph_last = PH_W'(PH_WRAP_LAST);
            default:                                         ph_last = '0;
        endcase
    end

    assign done = r_busy && (r_cnt == ph_last);

    // CORDIC operands and rounding
    always_comb begin
        y_src  = (r_cur == OP_ATAN_R) ? {r_ay[SAMP_W-1], r_ay} : -{r_ax[SAMP_W-1], r_ax};
        x_src  = {r_az[SAMP_W-1], r_az};
        x_init = {{(CORDIC_W-SAMP_W-1-CORDIC_PRESHIFT){x_src[SAMP_W]}}, x_src,
                  {CORDIC_PRESHIFT{1'b0}}};
        y_init = {{(CORDIC_W-SAMP_W-1-CORDIC_PRESHIFT){y_src[SAMP_W]}}, y_src,
                  {CORDIC_PRESHIFT{1'b0}}};
        c_idx  = 4'(r_cnt - PH_W'(1));
        xs     = r_cx >>> c_idx;
        ys     = r_cy >>> c_idx;
        z_rnd  = (r_cz + Z_W'(2 ** (15 - ANGLE_FRAC_BITS))) >>> (16 - ANGLE_FRAC_BITS);
        z_w    = z_rnd[ANGLE_W:0];
        if (z_w > HALF_TURN) begin
            z_fix = (ANGLE_W+1)'(z_w - FULL_TURN);
        end else if (z_w < -HALF_TURN) begin
            z_fix = (ANGLE_W+1)'(z_w + FULL_TURN);
        end else begin
            z_fix = z_w;
        end
    end

    // divider operands
    always_comb begin
        is_gyro = (r_cur == OP_GYRO_X) || (r_cur == OP_GYRO_Y) || (r_cur == OP_GYRO_Z);
        case (r_cur)
            OP_GYRO_X: begin g_sel = r_gx; est_sel = r_roll;  end
            OP_GYRO_Y: begin g_sel = r_gy; est_sel = r_pitch; end
            default:   begin g_sel = r_gz; est_sel = r_yaw;   end
        endcase
        g_mag   = g_sel[SAMP_W-1] ? SAMP_W'(-g_sel) : g_sel;
        lsb_eff = (r_lsb == '0) ? LSB_W'(1) : r_lsb;
        d_gyro  = DVS_W'(lsb_eff * LSB_SCALE);
        g_prod  = g_mag * r_period;
        sum_sel = (r_cur == OP_INIT_R) ? r_sum_r : r_sum_p;
        sum_mag = sum_sel[SUM_W-1] ? SUM_W'(-sum_sel) : sum_sel;
        trial   = {r_rem, r_mag[DIV_W-1]};
        ge      = trial >= {1'b0, r_dv};
        q_lo    = r_quo[EXT_W-1:0];
        q_sgn   = r_neg ? EXT_W'(-q_lo) : q_lo;
    end

    // blend and wrap
    always_comb begin
        gyro_ang = (r_cur == OP_BLEND_R) ? r_rg : r_pg;
        acc_ang  = (r_cur == OP_BLEND_R) ? EXT_W'(r_ar) : EXT_W'(r_ap);
        w_gyro   = WGT_W'({1'b0, r_gain});
        w_acc    = WGT_W'(GAIN_ONE) - w_gyro;
        bsum     = BSUM_W'(r_m1) + BSUM_W'(r_m2) + BSUM_W'(GAIN_HALF);
        w_k      = 3'(PH_W'(PH_WRAP_LAST - 1) - r_cnt);
        wv_e     = (EXT_W+1)'(r_wv);
        w_step   = (EXT_W+1)'(FULL_TURN) <<< w_k;
        t_dn     = wv_e - w_step;
        t_up     = wv_e + w_step;
        if (wv_e > HALF_TURN) begin
            w_fin = (EXT_W+1)'(wv_e - FULL_TURN);
        end else if (wv_e < -HALF_TURN) begin
            w_fin = (EXT_W+1)'(wv_e + FULL_TURN);
        end else begin
            w_fin = wv_e;
        end
    end

    // config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain   <= GAIN_RST;
            r_period <= PERIOD_RST;
            r_lsb    <= LSB_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_BLEND_GAIN: r_gain   <= i_cfg_data[GAIN_W-1:0];
                CFG_PERIOD:     r_period <= i_cfg_data[PER_W-1:0];
                CFG_GYRO_LSB:   r_lsb    <= i_cfg_data[LSB_W-1:0];
                default:        ;
            endcase
        end
    end

    // sample latch and output capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op <= i_operation;
            r_ok <= i_sample_ok;
            r_ax <= i_accel_x;
            r_ay <= i_accel_y;
            r_az <= i_accel_z;
            r_gx <= i_gyro_x;
            r_gy <= i_gyro_y;
            r_gz <= i_gyro_z;
        end
        if (i_cmd.capture) begin
            r_out_roll  <= r_roll;
            r_out_pitch <= r_pitch;
            r_out_yaw   <= r_yaw;
        end
    end

    // operation sequencing and filter state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_cur     <= OP_ACCUM;
            r_cnt     <= '0;
            r_roll    <= '0;
            r_pitch   <= '0;
            r_yaw     <= '0;
            r_sum_r   <= '0;
            r_sum_p   <= '0;
            r_count   <= '0;
            r_pending <= 1'b1;
        end else begin
            if (i_cmd.start) begin
                r_busy <= 1'b1;
                r_cur  <= i_cmd.op;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (done) begin
                    r_busy <= 1'b0;
                end else begin
                    r_cnt <= r_cnt + PH_W'(1);
                end
                case (r_cur)
                    OP_ATAN_R, OP_ATAN_P: begin
                        if (r_cnt == '0) begin
                            r_zero <= (x_src == '0) && (y_src == '0);
                            if (x_src < 0) begin
                                r_cx <= -x_init;
                                r_cy <= -y_init;
                                r_cz <= (y_src >= 0) ? Z_W'(DEG180_Q16) : Z_W'(-DEG180_Q16);
                            end else begin
                                r_cx <= x_init;
                                r_cy <= y_init;
                                r_cz <= '0;
                            end
                        end else if (r_cnt < PH_W'(PH_ATAN_LAST)) begin
                            if (r_cy > 0) begin
                                r_cx <= r_cx + ys;
                                r_cy <= r_cy - xs;
                                r_cz <= r_cz + $signed(ATAN_TAB[c_idx]);
                            end else begin
                                r_cx <= r_cx - ys;
                                r_cy <= r_cy + xs;
                                r_cz <= r_cz - $signed(ATAN_TAB[c_idx]);
                            end
                        end else if (r_cur == OP_ATAN_R) begin
                            r_ar <= r_zero ? '0 : z_fix[ANGLE_W-1:0];
                        end else begin
                            r_ap <= r_zero ? '0 : z_fix[ANGLE_W-1:0];
                        end
                    end
                    OP_ACCUM: begin
                        r_sum_r <= r_sum_r + SUM_W'(r_ar);
                        r_sum_p <= r_sum_p + SUM_W'(r_ap);
                        r_count <= r_count + CNT_W'(1);
                    end
                    OP_INIT_FIN: begin
                        if (r_count == '0) begin
                            r_roll  <= '0;
                            r_pitch <= '0;
                        end
                        r_yaw     <= '0;
                        r_sum_r   <= '0;
                        r_sum_p   <= '0;
                        r_count   <= '0;
                        r_pending <= 1'b0;
                    end
                    OP_INIT_R, OP_INIT_P, OP_GYRO_X, OP_GYRO_Y, OP_GYRO_Z: begin
                        if (r_cnt == '0) begin
                            if (is_gyro) begin
                                r_mag <= DIV_W'(g_prod);
                                r_dv  <= d_gyro;
                                r_neg <= g_sel[SAMP_W-1];
                            end else begin
                                r_mag <= DIV_W'(sum_mag);
                                r_dv  <= DVS_W'(r_count);
                                r_neg <= sum_sel[SUM_W-1];
                            end
                        end else if (r_cnt == PH_W'(1)) begin
                            r_rem <= '0;
                            r_quo <= '0;
                            if (is_gyro) begin
                                r_mag <= (r_mag << ANGLE_FRAC_BITS) + DIV_W'(r_dv >> 1);
                            end else begin
                                r_mag <= r_mag + DIV_W'(r_dv >> 1);
                            end
                        end else if (r_cnt < PH_W'(PH_DIV_LAST)) begin
                            // one restoring quotient bit a cycle
                            r_mag <= r_mag << 1;
                            r_quo <= {r_quo[DIV_W-2:0], ge};
                            r_rem <= ge ? DVS_W'(trial - {1'b0, r_dv}) : DVS_W'(trial);
                        end else begin
                            case (r_cur)
                                OP_INIT_R: r_roll  <= q_sgn[ANGLE_W-1:0];
                                OP_INIT_P: r_pitch <= q_sgn[ANGLE_W-1:0];
                                OP_GYRO_X: r_rg    <= EXT_W'(est_sel) + q_sgn;
                                OP_GYRO_Y: r_pg    <= EXT_W'(est_sel) + q_sgn;
                                default:   r_yg    <= EXT_W'(est_sel) + q_sgn;
                            endcase
                        end
                    end
                    OP_BLEND_R, OP_BLEND_P, OP_WRAP_Y: begin
                        if (r_cnt == '0) begin
                            r_m1 <= w_gyro * gyro_ang;
                        end else if (r_cnt == PH_W'(1)) begin
                            r_m2 <= w_acc * acc_ang;
                        end else if (r_cnt == PH_W'(2)) begin
                            r_wv <= (r_cur == OP_WRAP_Y) ? r_yg : bsum[16 +: EXT_W];
                        end else if (r_cnt < PH_W'(PH_WRAP_LAST)) begin
                            // remove 2^k full turns while still above the band, add them while still below
                            if (wv_e > HALF_TURN) begin
                                if (t_dn > HALF_TURN) r_wv <= t_dn[EXT_W-1:0];
                            end else if (wv_e < -HALF_TURN) begin
                                if (t_up < -HALF_TURN) r_wv <= t_up[EXT_W-1:0];
                            end
                        end else begin
                            case (r_cur)
                                OP_BLEND_R: r_roll  <= w_fin[ANGLE_W-1:0];
                                OP_BLEND_P: r_pitch <= w_fin[ANGLE_W-1:0];
                                default:    r_yaw   <= w_fin[ANGLE_W-1:0];
                            endcase
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    assign o_sts.busy         = r_busy;
    assign o_sts.done         = done;
    assign o_sts.operation    = r_op;
    assign o_sts.sample_ok    = r_ok;
    assign o_sts.init_pending = r_pending;
    assign o_sts.count_zero   = (r_count == '0);
    assign o_sts.count_room   = (r_count < CNT_W'(INIT_SAMPLES_MAX));

    assign o_roll  = r_out_roll;
    assign o_pitch = r_out_pitch;
    assign o_yaw   = r_out_yaw;

endmodule

// ----- src/icaf_ctrl.sv -----
// ---------------------------------------------------------------------------
// icaf_ctrl: attitude filter controller
// Walks the datapath through the operations of one item and owns the
// input ready and result valid handshakes.
// ---------------------------------------------------------------------------
module icaf_ctrl import icaf_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_dp_cmd o_cmd,
    input  t_dp_sts i_sts
);

    typedef enum logic [3:0] {
        S_IDLE, S_DECIDE, S_ATAN_R, S_ATAN_P, S_ACCUM, S_INIT_R, S_INIT_P,
        S_INIT_FIN, S_GYRO_X, S_GYRO_Y, S_GYRO_Z, S_BLEND_R, S_BLEND_P,
        S_WRAP_Y, S_OUT
    } t_state;

    t_state r_state, n_state;
    logic   r_issued;
    logic   r_out_valid;
    logic   is_op;
    t_dp_op op;
    logic   capture;

    // operation issued by each working state
    always_comb begin
        is_op = 1'b1;
        unique case (r_state)
            S_ATAN_R:   op = OP_ATAN_R;
            S_ATAN_P:   op = OP_ATAN_P;
            S_ACCUM:    op = OP_ACCUM;
            S_INIT_R:   op = OP_INIT_R;
            S_INIT_P:   op = OP_INIT_P;
            S_INIT_FIN: op = OP_INIT_FIN;
            S_GYRO_X:   op = OP_GYRO_X;
            S_GYRO_Y:   op = OP_GYRO_Y;
            S_GYRO_Z:   op = OP_GYRO_Z;
            S_BLEND_R:  op = OP_BLEND_R;
            S_BLEND_P:  op = OP_BLEND_P;
            S_WRAP_Y:   op = OP_WRAP_Y;
            default: begin
                op    = OP_ACCUM;
                is_op = 1'b0;
            end
        endcase
    end

    assign capture = (r_state == S_OUT) && (!r_out_valid || i_out_ready);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:     if (i_in_valid) n_state = S_DECIDE;
            S_DECIDE: begin
                if (!i_sts.operation) begin
                    n_state = (i_sts.sample_ok && i_sts.init_pending && i_sts.count_room)
                            ? S_ATAN_R : S_OUT;
                end else if (i_sts.init_pending) begin
                    n_state = i_sts.count_zero ? S_INIT_FIN : S_INIT_R;
                end else begin
                    n_state = i_sts.sample_ok ? S_GYRO_X : S_OUT;
                end
            end
            S_ATAN_R:   if (i_sts.done) n_state = S_ATAN_P;
            S_ATAN_P:   if (i_sts.done) n_state = i_sts.operation ? S_BLEND_R : S_ACCUM;
            S_ACCUM:    if (i_sts.done) n_state = S_OUT;
            S_INIT_R:   if (i_sts.done) n_state = S_INIT_P;
            S_INIT_P:   if (i_sts.done) n_state = S_INIT_FIN;
            S_INIT_FIN: if (i_sts.done) n_state = i_sts.sample_ok ? S_GYRO_X : S_OUT;
            S_GYRO_X:   if (i_sts.done) n_state = S_GYRO_Y;
            S_GYRO_Y:   if (i_sts.done) n_state = S_GYRO_Z;
            S_GYRO_Z:   if (i_sts.done) n_state = S_ATAN_R;
            S_BLEND_R:  if (i_sts.done) n_state = S_BLEND_P;
            S_BLEND_P:  if (i_sts.done) n_state = S_WRAP_Y;
            S_WRAP_Y:   if (i_sts.done) n_state = S_OUT;
            S_OUT:      if (capture) n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    // state, issue flag and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_issued    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_sts.done) begin
                r_issued <= 1'b0;
            end else if (o_cmd.start) begin
                r_issued <= 1'b1;
            end
            if (capture) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_in_ready    = (r_state == S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_cmd.load    = i_in_valid && o_in_ready;
    assign o_cmd.start   = is_op && !r_issued;
    assign o_cmd.op      = op;
    assign o_cmd.capture = capture;

endmodule
